// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the stream codec.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NXC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define NXC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define NXC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NXC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/nxc_pkg.sv -----
// Package for the netchan XOR stream codec: sizes, codes and character constants.
// No dependencies.
`timescale 1ns / 1ps

package nxc_pkg;

    localparam int COMMAND_SLOTS = 64;      // power of two
    localparam int COMMAND_LEN   = 1024;    // power of two
    localparam int MAX_MESSAGE   = 16384;   // power of two

    localparam int SLOT_W      = $clog2(COMMAND_SLOTS);
    localparam int IDX_W       = $clog2(COMMAND_LEN);
    localparam int ADDR_W      = SLOT_W + IDX_W;
    localparam int STORE_DEPTH = COMMAND_SLOTS * COMMAND_LEN;
    localparam int POS_W       = $clog2(MAX_MESSAGE);

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_MSG  = 1'b1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    typedef enum logic [1:0] {
        REG_DIRECTION  = 2'd0,
        REG_CHALLENGE  = 2'd1,
        REG_HEADER_LEN = 2'd2
    } cfg_reg_t;

    localparam logic [4:0] HEADER_LEN_RESET = 5'd4;

    localparam logic [7:0] ENC_KEY2_POS   = 8'd4;
    localparam logic [7:0] ENC_SLOT_POS   = 8'd8;
    localparam logic [7:0] ENC_BODY_START = 8'd12;
    localparam logic [7:0] DEC_BODY_AFTER = 8'd4;

    localparam logic [7:0] CHAR_MAX_PLAIN = 8'd127;
    localparam logic [7:0] CHAR_PERCENT   = 8'h25;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;

endpackage

// ----- rtl/netchan_xor_stream_codec.sv -----
// Netchan XOR stream codec: command string store plus rolling-key message path.
// Depends on nxc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
// An accepted message byte is registered in the output register, or in the skid entry
// if that register is stalled. One beat (load or message byte) per cycle while s_tready is
// high; the store read for the next key step is issued in the cycle of the current byte.
// Output stage is a register plus a skid entry; s_tready drops only when both are full.
// Reset clears key, position, index, slot, registers and output stage; the
// command store is not cleared and holds garbage until loaded.
`include "assert_macros.svh"

module netchan_xor_stream_codec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // slot [5:0], offset [15:6], data_byte [23:16]
    input  logic        s_tuser,   // func
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte [7:0]
    output logic        m_tlast,   // out_last
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    // configuration
    logic       dir_reg;
    logic [7:0] chal_reg;
    logic [4:0] hdr_len_reg;

    // message state
    logic [nxc_pkg::POS_W-1:0]  pos_reg, pos_next, pos_inc;
    logic [7:0]                 key_reg, key_next;
    logic [nxc_pkg::IDX_W-1:0]  idx_reg, idx_next, idx_eff;
    logic [nxc_pkg::SLOT_W-1:0] sel_reg, sel_next;

    // store and read ports
    logic [7:0]                 store_mem [0:nxc_pkg::STORE_DEPTH-1];
    logic [nxc_pkg::ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;
    logic                       wr_en;
    logic [7:0]                 rd_a_q_reg, rd_b_q_reg;
    logic                       fwd_a_valid_reg, fwd_b_valid_reg;
    logic [7:0]                 fwd_a_data_reg, fwd_b_data_reg;

    // output stage
    logic       out_valid_reg, skid_valid_reg;
    logic [7:0] out_byte_reg, skid_byte_reg;
    logic       out_last_reg, skid_last_reg;

    logic                      in_fire, msg_fire, load_fire, load_ok, out_fire;
    logic [nxc_pkg::SLOT_W-1:0] in_slot;
    logic [9:0]                in_offset;
    logic [7:0]                in_data;
    logic [7:0]                cur_char, first_char, char_sel, char_clean, key_mix;
    logic                      char_nul, in_body;
    logic [nxc_pkg::POS_W-1:0] body_start;
    logic [7:0]                result_byte;

    assign in_slot   = nxc_pkg::SLOT_W'(s_tdata[5:0]);
    assign in_offset = s_tdata[15:6];
    assign in_data   = s_tdata[23:16];

    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;
    assign msg_fire  = in_fire && (s_tuser == nxc_pkg::FUNC_MSG);
    assign load_fire = in_fire && (s_tuser == nxc_pkg::FUNC_LOAD);
    assign load_ok   = (int'(s_tdata[5:0]) < nxc_pkg::COMMAND_SLOTS)
                    && (int'(in_offset) < nxc_pkg::COMMAND_LEN);
    assign out_fire  = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg     <= nxc_pkg::DIR_ENCODE;
            chal_reg    <= 8'd0;
            hdr_len_reg <= nxc_pkg::HEADER_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (nxc_pkg::cfg_reg_t'(cfg_index))
                nxc_pkg::REG_DIRECTION:  dir_reg     <= cfg_wdata[0];
                nxc_pkg::REG_CHALLENGE:  chal_reg    <= cfg_wdata[7:0];
                nxc_pkg::REG_HEADER_LEN: hdr_len_reg <= cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // character selection and key step
    always_comb
    begin
        cur_char   = fwd_a_valid_reg ? fwd_a_data_reg : rd_a_q_reg;
        first_char = fwd_b_valid_reg ? fwd_b_data_reg : rd_b_q_reg;
        char_nul   = (cur_char == 8'd0);
        char_sel   = char_nul ? first_char : cur_char;
        idx_eff    = char_nul ? '0 : idx_reg;
        char_clean = ((char_sel > nxc_pkg::CHAR_MAX_PLAIN) || (char_sel == nxc_pkg::CHAR_PERCENT))
                   ? nxc_pkg::CHAR_DOT : char_sel;
        key_mix    = pos_reg[0] ? {char_clean[6:0], 1'b0} : char_clean;
        body_start = (dir_reg == nxc_pkg::DIR_ENCODE)
                   ? nxc_pkg::POS_W'(nxc_pkg::ENC_BODY_START)
                   : nxc_pkg::POS_W'({3'b000, hdr_len_reg} + nxc_pkg::DEC_BODY_AFTER);
        in_body    = (pos_reg >= body_start);
        pos_inc    = pos_reg + 1'b1;
    end

    // next message state
    always_comb
    begin
        pos_next    = pos_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        sel_next    = sel_reg;
        result_byte = in_data;
        if (msg_fire)
        begin
            if (pos_reg == '0)
            begin
                key_next = chal_reg ^ in_data;
            end
            if (dir_reg == nxc_pkg::DIR_ENCODE)
            begin
                if (pos_reg == nxc_pkg::POS_W'(nxc_pkg::ENC_KEY2_POS))
                begin
                    key_next = key_reg ^ in_data;
                end
                if (pos_reg == nxc_pkg::POS_W'(nxc_pkg::ENC_SLOT_POS))
                begin
                    sel_next = nxc_pkg::SLOT_W'(in_data);
                end
            end
            else if (pos_reg == nxc_pkg::POS_W'(hdr_len_reg))
            begin
                sel_next = nxc_pkg::SLOT_W'(in_data);
            end
            if (in_body)
            begin
                key_next    = key_reg ^ key_mix;
                idx_next    = idx_eff + 1'b1;
                result_byte = in_data ^ key_next;
            end
            if (s_tlast)
            begin
                pos_next = '0;
                key_next = 8'd0;
                idx_next = '0;
                sel_next = '0;
            end
            else
            begin
                pos_next = pos_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            key_reg <= 8'd0;
            idx_reg <= '0;
            sel_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            key_reg <= key_next;
            idx_reg <= idx_next;
            sel_reg <= sel_next;
        end
    end

    // command store: one write port, two registered read ports
    assign wr_en     = load_fire && load_ok;
    assign wr_addr   = {in_slot, nxc_pkg::IDX_W'(in_offset)};
    assign rd_addr_a = {sel_next, idx_next};
    assign rd_addr_b = {sel_next, {nxc_pkg::IDX_W{1'b0}}};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= in_data;
        end
        rd_a_q_reg     <= store_mem[rd_addr_a];
        rd_b_q_reg     <= store_mem[rd_addr_b];
        fwd_a_data_reg <= in_data;
        fwd_b_data_reg <= in_data;
    end

    // bypass a load that lands on an address being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_a_valid_reg <= 1'b0;
            fwd_b_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_a_valid_reg <= wr_en && (wr_addr == rd_addr_a);
            fwd_b_valid_reg <= wr_en && (wr_addr == rd_addr_b);
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (msg_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_byte_reg <= skid_byte_reg;
                out_last_reg <= skid_last_reg;
            end
        end
        else if (msg_fire)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_byte_reg <= result_byte;
                out_last_reg <= s_tlast;
            end
            else
            begin
                skid_byte_reg <= result_byte;
                skid_last_reg <= s_tlast;
            end
        end
    end

    `NXC_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `NXC_ASSERT_NXT(a_last_clears, clk, rst_n, msg_fire && s_tlast, (pos_reg == '0) && (key_reg == 8'd0) && (idx_reg == '0))
    `NXC_ASSERT_NXT(a_pos_advance, clk, rst_n, msg_fire && !s_tlast, pos_reg == $past(pos_inc))
    `NXC_ASSERT_NXT(a_load_no_beat, clk, rst_n, load_fire && !out_valid_reg, !out_valid_reg)

endmodule

// ----- tb/netchan_xor_stream_codec_tb.sv -----
// Self-checking testbench for netchan_xor_stream_codec: loads command strings, streams
// messages under both directions and several register settings, and checks every output beat.
// Depends on nxc_pkg and the RTL of the codec.
`timescale 1ns / 1ps

module netchan_xor_stream_codec_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_REPORTS = 10;
    localparam int LONG_HOLD   = 300;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } codec_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // slot [5:0], offset [15:6], data_byte [23:16]
    logic        s_tuser = 1'b0;  // func
    logic        s_tlast = 1'b0;  // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // out_byte [7:0]
    logic        m_tlast;         // out_last
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    netchan_xor_stream_codec DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Predictor state and register copies
    logic [7:0]                 cmd_copy [nxc_pkg::STORE_DEPTH];
    logic [nxc_pkg::POS_W-1:0]  msg_pos  = '0;
    logic [7:0]                 roll_key = '0;
    logic [nxc_pkg::IDX_W-1:0]  str_idx  = '0;
    logic [nxc_pkg::SLOT_W-1:0] cur_slot = '0;
    logic                       dir_r    = nxc_pkg::DIR_ENCODE;
    logic [31:0]                chal_r   = '0;
    logic [4:0]                 hlen_r   = nxc_pkg::HEADER_LEN_RESET;

    codec_out_t  expected_out [$];
    int          str_fill [nxc_pkg::COMMAND_SLOTS];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        rx_hold = 1'b0;
    event        long_hold_ev;
    int unsigned cycle_cnt = 0;
    int          err_count = 0;
    int          n_loads = 0;
    int          n_msg = 0;
    int          n_checked = 0;
    int          n_cfg = 0;

    function automatic void log_error(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t mismatch: %s", $time, what);
    endfunction

    function automatic void codec_predict(input logic func,
                                          input logic [nxc_pkg::SLOT_W-1:0] slot,
                                          input logic [nxc_pkg::IDX_W-1:0] offs,
                                          input logic [7:0] d, input logic last);
        logic [7:0] ch;
        logic [7:0] outb;
        int         body_start;
        codec_out_t res;
        outb = d;
        if (func == nxc_pkg::FUNC_LOAD)
        begin
            cmd_copy[{slot, offs}] = d;
            return;
        end
        if (dir_r == nxc_pkg::DIR_ENCODE)
        begin
            body_start = int'(nxc_pkg::ENC_BODY_START);
            if (msg_pos == 0) roll_key = chal_r[7:0] ^ d;
            if (msg_pos == nxc_pkg::POS_W'(nxc_pkg::ENC_KEY2_POS)) roll_key = roll_key ^ d;
            if (msg_pos == nxc_pkg::POS_W'(nxc_pkg::ENC_SLOT_POS))
                cur_slot = d[nxc_pkg::SLOT_W-1:0];
        end
        else
        begin
            body_start = int'(hlen_r) + int'(nxc_pkg::DEC_BODY_AFTER);
            if (msg_pos == 0) roll_key = chal_r[7:0] ^ d;
            if (msg_pos == nxc_pkg::POS_W'(hlen_r)) cur_slot = d[nxc_pkg::SLOT_W-1:0];
        end
        if (int'(msg_pos) >= body_start)
        begin
            ch = cmd_copy[{cur_slot, str_idx}];
            if (ch == 8'h00)
            begin
                str_idx = '0;
                ch = cmd_copy[{cur_slot, str_idx}];
            end
            if (ch > nxc_pkg::CHAR_MAX_PLAIN || ch == nxc_pkg::CHAR_PERCENT)
                ch = nxc_pkg::CHAR_DOT;
            if (msg_pos[0]) ch = {ch[6:0], 1'b0};
            roll_key = roll_key ^ ch;
            str_idx = str_idx + 1'b1;
            outb = d ^ roll_key;
        end
        res.out_byte = outb;
        res.out_last = last;
        expected_out.push_back(res);
        if (last)
        begin
            msg_pos = '0;
            roll_key = '0;
            str_idx = '0;
            cur_slot = '0;
        end
        else
        begin
            msg_pos = msg_pos + 1'b1;
        end
    endfunction

    function automatic void check_result(input logic [7:0] got_byte, input logic got_last);
        codec_out_t want;
        n_checked++;
        if (expected_out.size() == 0)
        begin
            log_error($sformatf("unexpected beat out_byte=%02h out_last=%0b",
                                got_byte, got_last));
            return;
        end
        want = expected_out.pop_front();
        if (got_byte !== want.out_byte)
            log_error($sformatf("out_byte expected %02h got %02h", want.out_byte, got_byte));
        if (got_last !== want.out_last)
            log_error($sformatf("out_last expected %0b got %0b", want.out_last, got_last));
    endfunction

    function automatic logic [7:0] random_char();
        logic [7:0] c;
        c = 8'($urandom_range(255, 1));
        if ($urandom_range(9) == 0) c = nxc_pkg::CHAR_PERCENT;
        return c;
    endfunction

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    // Hold off the receiver for a long stretch on request
    always
    begin
        @(long_hold_ev);
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready) check_result(m_tdata, m_tlast);
        m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_cnt, expected_out.size());
        $display("netchan_xor_stream_codec_tb: errors");
        $finish;
    end

    task automatic send_beat(input logic func, input logic [nxc_pkg::SLOT_W-1:0] slot,
                             input logic [nxc_pkg::IDX_W-1:0] offs, input logic [7:0] d,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {d, offs, slot};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        codec_predict(func, slot, offs, d, last);
        if (func == nxc_pkg::FUNC_MSG) n_msg++;
        else n_loads++;
    endtask

    task automatic load_byte(input int slot, input int offs, input logic [7:0] d);
        logic junk_last;
        junk_last = 1'($urandom_range(1));
        send_beat(nxc_pkg::FUNC_LOAD, slot[nxc_pkg::SLOT_W-1:0], offs[nxc_pkg::IDX_W-1:0],
                  d, junk_last);
    endtask

    task automatic msg_byte(input logic [7:0] d, input logic last);
        logic [nxc_pkg::SLOT_W-1:0] junk_slot;
        logic [nxc_pkg::IDX_W-1:0]  junk_offs;
        junk_slot = nxc_pkg::SLOT_W'($urandom());
        junk_offs = nxc_pkg::IDX_W'($urandom());
        send_beat(nxc_pkg::FUNC_MSG, junk_slot, junk_offs, d, last);
    endtask

    // Write from the terminator down so a reader never walks into an unwritten entry.
    task automatic load_string(input int slot, input int len);
        int top;
        int o;
        top = (len >= nxc_pkg::COMMAND_LEN) ? nxc_pkg::COMMAND_LEN - 1 : len;
        for (o = top; o >= 0; o--)
            load_byte(slot, o, (o == len) ? 8'h00 : random_char());
        if (top + 1 > str_fill[slot]) str_fill[slot] = top + 1;
    endtask

    // Rewrite one entry below the slot's closing NUL; a NUL at entry 0 is itself rewritten.
    task automatic poke_store();
        int s;
        int lim;
        s = int'($urandom_range(nxc_pkg::COMMAND_SLOTS - 1));
        lim = (str_fill[s] >= nxc_pkg::COMMAND_LEN) ? nxc_pkg::COMMAND_LEN - 1
                                                    : str_fill[s] - 2;
        if (lim < 0) load_byte(s, 0, 8'h00);
        else load_byte(s, int'($urandom_range(lim)), 8'($urandom_range(255)));
    endtask

    task automatic send_message(input int len, input int pick_pos, input logic [7:0] pick_val,
                                input bit mix_loads);
        int         i;
        logic [7:0] d;
        for (i = 0; i < len; i++)
        begin
            if (mix_loads && $urandom_range(15) == 0) poke_store();
            d = (i == pick_pos) ? pick_val : 8'($urandom_range(255));
            msg_byte(d, i == len - 1);
        end
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input nxc_pkg::cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            nxc_pkg::REG_DIRECTION:  dir_r  = value[0];
            nxc_pkg::REG_CHALLENGE:  chal_r = value;
            nxc_pkg::REG_HEADER_LEN: hlen_r = value[4:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic random_reconfig();
        nxc_pkg::cfg_reg_t which;
        logic [31:0]       v;
        which = nxc_pkg::cfg_reg_t'($urandom_range(2));
        wait_for_results();
        case (which)
            nxc_pkg::REG_DIRECTION:  write_reg(nxc_pkg::REG_DIRECTION, $urandom_range(1));
            nxc_pkg::REG_CHALLENGE:
            begin
                v = $urandom();
                if ($urandom_range(3) == 0) v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                write_reg(nxc_pkg::REG_CHALLENGE, v);
            end
            default:                 write_reg(nxc_pkg::REG_HEADER_LEN, $urandom_range(16));
        endcase
    endtask

    task automatic test_store_setup();
        int s;
        for (s = 0; s < nxc_pkg::COMMAND_SLOTS; s++) str_fill[s] = 0;
        for (s = 0; s < nxc_pkg::COMMAND_SLOTS; s++) load_string(s, int'($urandom_range(3)));
    endtask

    // Reset register values; slot 1 carries every character rule, slot 2 is empty.
    task automatic test_directed_encode();
        logic [7:0] specials [5];
        logic [7:0] msg [18];
        int         i;
        specials = '{nxc_pkg::CHAR_PERCENT, 8'h7F, 8'h80, 8'hFF, 8'h41};
        msg = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h41,
                8'h01, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hAA, 8'h55};
        load_byte(1, 5, 8'h00);
        for (i = 4; i >= 0; i--) load_byte(1, i, specials[i]);
        if (str_fill[1] < 6) str_fill[1] = 6;
        load_byte(2, 0, 8'h00);
        for (i = 0; i < 18; i++) msg_byte(msg[i], i == 17);
    endtask

    task automatic test_decode_header_len();
        wait_for_results();
        write_reg(nxc_pkg::REG_DIRECTION, 32'(nxc_pkg::DIR_DECODE));
        write_reg(nxc_pkg::REG_CHALLENGE, 32'hFFFF_FFFF);
        write_reg(nxc_pkg::REG_HEADER_LEN, 32'd0);
        send_message(12, 0, 8'h02, 1'b0);
        send_message(3, -1, 8'h00, 1'b0);
        wait_for_results();
        write_reg(nxc_pkg::REG_CHALLENGE, 32'h8000_0001);
        write_reg(nxc_pkg::REG_HEADER_LEN, 32'd16);
        send_message(30, 16, 8'h41, 1'b0);
        send_message(19, -1, 8'h00, 1'b0);
    endtask

    task automatic test_config_sweep();
        logic        dir_set [5];
        logic [31:0] chal_set [5];
        int          hlen_set [5];
        int          k;
        dir_set  = '{nxc_pkg::DIR_ENCODE, nxc_pkg::DIR_ENCODE, nxc_pkg::DIR_DECODE,
                     nxc_pkg::DIR_DECODE, nxc_pkg::DIR_DECODE};
        chal_set = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h1234_565A};
        hlen_set = '{4, 16, 0, 16, 7};
        for (k = 0; k < 5; k++)
        begin
            wait_for_results();
            write_reg(nxc_pkg::REG_DIRECTION, 32'(dir_set[k]));
            write_reg(nxc_pkg::REG_CHALLENGE, chal_set[k]);
            write_reg(nxc_pkg::REG_HEADER_LEN, hlen_set[k]);
            send_message(int'($urandom_range(24, 8)), -1, 8'h00, 1'b0);
        end
    endtask

    task automatic test_backpressure();
        wait_for_results();
        -> long_hold_ev;
        send_message(40, -1, 8'h00, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(7) == 0) random_reconfig();
            if ($urandom_range(9) == 0)
                load_string(int'($urandom_range(nxc_pkg::COMMAND_SLOTS - 1)),
                            int'($urandom_range(8)));
            if ($urandom_range(4) == 0) len = int'($urandom_range(12, 1));
            else len = int'($urandom_range(32, 13));
            send_message(len, -1, 8'h00, 1'b1);
            sent += len;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_store_setup();
        test_directed_encode();
        test_decode_header_len();
        test_config_sweep();
        test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        test_random_traffic(45);
        send_idle_pct = 50;
        test_random_traffic(45);
        send_idle_pct = 0;
        stall_pct = 50;
        test_random_traffic(45);
        send_idle_pct = 19;
        stall_pct = 19;
        test_random_traffic(45);
        wait_for_results();
        repeat (8) @(posedge clk);
        if (expected_out.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_out.size()));
        $display("run: %0d store loads, %0d message bytes, both directions, header_len 0..16,",
                 n_loads, n_msg);
        $display("     long receiver hold, %0d result beats compared, %0d register writes, %0d failures",
                 n_checked, n_cfg, err_count);
        if (err_count == 0)
            $display("netchan_xor_stream_codec_tb: clean");
        else
            $display("netchan_xor_stream_codec_tb: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/nxc_pkg.sv
rtl/netchan_xor_stream_codec.sv
tb/netchan_xor_stream_codec_tb.sv
